[hw/rtl/imgrot_pkg.sv]
// Package for the 90-degree counterclockwise frame rotator.
// Holds the payload structs, controller/datapath command and status structs,
// the phase enum and register codes. No dependencies.
`default_nettype none

package imgrot_pkg;

   localparam int MAX_DIM_DEFAULT = 128;
   localparam int CHAN_W          = 8;
   localparam int COORD_W         = 7;
   localparam int PIXEL_W         = 3 * CHAN_W;
   localparam int DIM_REG_W       = 8;
   localparam int CSR_DATA_W      = 32;
   localparam int CSR_ADDR_W      = 3;
   localparam int CSR_IDX_BIT     = 2;

   localparam logic [DIM_REG_W-1:0] DIM_RESET = 8'd128;

   // register index codes (paddr bit CSR_IDX_BIT)
   localparam logic REG_IMAGE_WIDTH  = 1'b0;
   localparam logic REG_IMAGE_HEIGHT = 1'b1;

   // item mode codes
   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_DRAIN = 1'b1;

   typedef enum logic {
      ST_LOAD,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      logic              mode;
      logic [CHAN_W-1:0] in_blue;
      logic [CHAN_W-1:0] in_green;
      logic [CHAN_W-1:0] in_red;
   } req_type;

   typedef struct packed {
      logic [CHAN_W-1:0]  out_blue;
      logic [CHAN_W-1:0]  out_green;
      logic [CHAN_W-1:0]  out_red;
      logic [COORD_W-1:0] out_row;
      logic [COORD_W-1:0] out_col;
      logic               last;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load_en;   // write pixel, advance load counters
      logic drain_en;  // issue read, advance drain counters
      logic out_load;  // move read data into output register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic load_wrap;   // current load is the last pixel of the frame
      logic drain_wrap;  // current drain is the last pixel of the frame
   } sts_type;

endpackage

`default_nettype wire

[hw/rtl/imgrot_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module imgrot_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 16384,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[hw/rtl/imgrot_ctrl.sv]
// Controller of the frame rotator: load/drain phase FSM and the
// handshake for the read stage and output register. Uses imgrot_pkg.
`default_nettype none

module imgrot_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_mode,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output imgrot_pkg::cmd_type     cmd,
   input  wire imgrot_pkg::sts_type sts
);

   imgrot_pkg::state_type state_ff, state_in;
   logic p1_valid_ff, p1_valid_in;
   logic out_valid_ff, out_valid_in;
   logic out_free;
   logic accept;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign req_stall = p1_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = out_valid_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         imgrot_pkg::ST_LOAD: begin
            if (cmd.load_en && sts.load_wrap) begin
               state_in = imgrot_pkg::ST_DRAIN;
            end
         end
         imgrot_pkg::ST_DRAIN: begin
            if (cmd.drain_en && sts.drain_wrap) begin
               state_in = imgrot_pkg::ST_LOAD;
            end
         end
         default: state_in = imgrot_pkg::ST_LOAD;
      endcase
   end

   // outputs; items of the wrong phase are taken and dropped
   always_comb begin
      cmd.load_en  = 1'b0;
      cmd.drain_en = 1'b0;
      unique case (state_ff)
         imgrot_pkg::ST_LOAD: begin
            cmd.load_en = accept && (req_mode == imgrot_pkg::MODE_LOAD);
         end
         imgrot_pkg::ST_DRAIN: begin
            cmd.drain_en = accept && (req_mode == imgrot_pkg::MODE_DRAIN);
         end
         default: begin
            cmd.load_en  = 1'b0;
            cmd.drain_en = 1'b0;
         end
      endcase
      cmd.out_load = p1_valid_ff && out_free;
   end

   assign p1_valid_in  = cmd.drain_en || (p1_valid_ff && !out_free);
   assign out_valid_in = cmd.out_load || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= imgrot_pkg::ST_LOAD;
         p1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         p1_valid_ff  <= p1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/imgrot_dp.sv]
// Datapath of the frame rotator: load/drain counters, address arithmetic,
// frame store and output register. Uses imgrot_pkg and imgrot_ram.
`default_nettype none

module imgrot_dp #(
   parameter int MAX_DIM = imgrot_pkg::MAX_DIM_DEFAULT,
   localparam int CNT_W = $clog2(MAX_DIM),
   localparam int DIM_W = CNT_W + 1
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [DIM_W-1:0]    w_dim,
   input  wire logic [DIM_W-1:0]    h_dim,
   input  wire imgrot_pkg::req_type req_data,
   input  wire imgrot_pkg::cmd_type cmd,
   output imgrot_pkg::sts_type      sts,
   output imgrot_pkg::rsp_type      rsp_data
);

   localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);
   localparam int EXT_W  = (CNT_W > imgrot_pkg::COORD_W) ? CNT_W : imgrot_pkg::COORD_W;

   logic [CNT_W-1:0] load_col_ff, load_col_in;
   logic [CNT_W-1:0] load_row_ff, load_row_in;
   logic [CNT_W-1:0] drain_row_ff, drain_row_in;
   logic [CNT_W-1:0] drain_col_ff, drain_col_in;

   logic [DIM_W-1:0] load_col_inc, load_row_inc, drain_col_inc, drain_row_inc;
   logic             load_col_wrap, load_row_wrap, drain_col_wrap, drain_row_wrap;
   logic [DIM_W-1:0] drain_row_ext;
   logic [DIM_W-1:0] src_col;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [imgrot_pkg::PIXEL_W-1:0] wr_pixel, rd_pixel;
   logic [EXT_W-1:0] row_ext, col_ext;

   logic [imgrot_pkg::COORD_W-1:0] p1_row_ff, p1_col_ff;
   logic                           p1_last_ff;
   imgrot_pkg::rsp_type            rsp_ff;

   assign load_col_inc   = DIM_W'(load_col_ff) + DIM_W'(1);
   assign load_row_inc   = DIM_W'(load_row_ff) + DIM_W'(1);
   assign drain_col_inc  = DIM_W'(drain_col_ff) + DIM_W'(1);
   assign drain_row_inc  = DIM_W'(drain_row_ff) + DIM_W'(1);
   assign load_col_wrap  = load_col_inc >= w_dim;
   assign load_row_wrap  = load_row_inc >= h_dim;
   assign drain_col_wrap = drain_col_inc >= h_dim;
   assign drain_row_wrap = drain_row_inc >= w_dim;

   assign sts.load_wrap  = load_col_wrap && load_row_wrap;
   assign sts.drain_wrap = drain_col_wrap && drain_row_wrap;

   // load counters: columns fastest
   always_comb begin
      load_col_in = load_col_ff;
      load_row_in = load_row_ff;
      if (cmd.load_en) begin
         if (load_col_wrap) begin
            load_col_in = '0;
            load_row_in = load_row_wrap ? '0 : load_row_inc[CNT_W-1:0];
         end else begin
            load_col_in = load_col_inc[CNT_W-1:0];
         end
      end
   end

   // drain counters walk the rotated raster
   always_comb begin
      drain_col_in = drain_col_ff;
      drain_row_in = drain_row_ff;
      if (cmd.drain_en) begin
         if (drain_col_wrap) begin
            drain_col_in = '0;
            drain_row_in = drain_row_wrap ? '0 : drain_row_inc[CNT_W-1:0];
         end else begin
            drain_col_in = drain_col_inc[CNT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_col_ff  <= '0;
         load_row_ff  <= '0;
         drain_row_ff <= '0;
         drain_col_ff <= '0;
      end else begin
         load_col_ff  <= load_col_in;
         load_row_ff  <= load_row_in;
         drain_row_ff <= drain_row_in;
         drain_col_ff <= drain_col_in;
      end
   end

   // source column w-1-r; a row past a shrunk width reads column 0
   assign drain_row_ext = DIM_W'(drain_row_ff);
   assign src_col = (drain_row_ext < w_dim) ? (w_dim - DIM_W'(1) - drain_row_ext) : '0;

   assign wr_addr = ADDR_W'(load_row_ff) * ADDR_W'(MAX_DIM) + ADDR_W'(load_col_ff);
   assign rd_addr = ADDR_W'(drain_col_ff) * ADDR_W'(MAX_DIM)
                  + ADDR_W'(src_col[CNT_W-1:0]);
   assign wr_pixel = {req_data.in_red, req_data.in_green, req_data.in_blue};

   imgrot_ram #(
      .WIDTH(imgrot_pkg::PIXEL_W),
      .DEPTH(MAX_DIM * MAX_DIM)
   ) u_store (
      .clock  (clock),
      .wr_en  (cmd.load_en),
      .wr_addr(wr_addr),
      .wr_data(wr_pixel),
      .rd_en  (cmd.drain_en),
      .rd_addr(rd_addr),
      .rd_data(rd_pixel)
   );

   assign row_ext = EXT_W'(drain_row_ff);
   assign col_ext = EXT_W'(drain_col_ff);

   // coordinates ride alongside the read
   always_ff @(posedge clock) begin
      if (cmd.drain_en) begin
         p1_row_ff  <= row_ext[imgrot_pkg::COORD_W-1:0];
         p1_col_ff  <= col_ext[imgrot_pkg::COORD_W-1:0];
         p1_last_ff <= sts.drain_wrap;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_ff.out_blue  <= rd_pixel[imgrot_pkg::CHAN_W-1:0];
         rsp_ff.out_green <= rd_pixel[2*imgrot_pkg::CHAN_W-1:imgrot_pkg::CHAN_W];
         rsp_ff.out_red   <= rd_pixel[3*imgrot_pkg::CHAN_W-1:2*imgrot_pkg::CHAN_W];
         rsp_ff.out_row   <= p1_row_ff;
         rsp_ff.out_col   <= p1_col_ff;
         rsp_ff.last      <= p1_last_ff;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

[hw/rtl/image_rotate_90_ccw_core.sv]
// Top level of the 90-degree counterclockwise frame rotator.
// Depends on imgrot_pkg, imgrot_ctrl, imgrot_dp (and imgrot_ram below it).
//
// Usage:
//   req channel (req_valid/req_stall/req_data): mode 0 beats write source
//   pixels in raster order; after width*height of them the block drains.
//   Mode 1 beats then each return one pixel of the rotated image on the
//   rsp channel (rsp_valid/rsp_stall/rsp_data), in rotated raster order; the
//   final one has last set and the block goes back to loading. Beats of the
//   wrong phase are taken and dropped without a result.
//   csr port: image_width at byte 0, image_height at byte 4 (8 bits each,
//   0 acts as 1, values above MAX_DIM act as MAX_DIM). Write only when idle.
// Timing: one beat per cycle in both phases while req_stall is low. A drain
//   result passes the registered read of the frame store, then the output
//   register, and turns valid once the output register is loaded.
// Stall: a stalled result holds; one more drain read may wait behind it,
//   after which req_stall rises until the output frees.
// Reset: loading phase, all counters zero, both dimensions 128. Frame store
//   contents are undefined until loaded; there is no clearing pass.
`default_nettype none

module image_rotate_90_ccw_core #(
   parameter int MAX_DIM = imgrot_pkg::MAX_DIM_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire imgrot_pkg::req_type                   req_data,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output imgrot_pkg::rsp_type                        rsp_data,
   input  wire logic                                  csr_psel,
   input  wire logic                                  csr_penable,
   input  wire logic                                  csr_pwrite,
   input  wire logic [imgrot_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [imgrot_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic      [imgrot_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                       csr_pready
);

   localparam int CNT_W = $clog2(MAX_DIM);
   localparam int DIM_W = CNT_W + 1;
   localparam int CMP_W = (DIM_W > imgrot_pkg::DIM_REG_W) ? DIM_W : imgrot_pkg::DIM_REG_W;

   logic [imgrot_pkg::DIM_REG_W-1:0] image_width_ff, image_width_in;
   logic [imgrot_pkg::DIM_REG_W-1:0] image_height_ff, image_height_in;
   logic                             csr_wr;
   logic                             csr_idx;
   logic [CMP_W-1:0]                 w_ext, h_ext, w_eff, h_eff;
   logic [DIM_W-1:0]                 w_dim, h_dim;

   imgrot_pkg::cmd_type cmd;
   imgrot_pkg::sts_type sts;

   // register port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[imgrot_pkg::CSR_IDX_BIT];

   always_comb begin
      image_width_in  = image_width_ff;
      image_height_in = image_height_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            imgrot_pkg::REG_IMAGE_WIDTH:
               image_width_in = csr_pwdata[imgrot_pkg::DIM_REG_W-1:0];
            imgrot_pkg::REG_IMAGE_HEIGHT:
               image_height_in = csr_pwdata[imgrot_pkg::DIM_REG_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= imgrot_pkg::DIM_RESET;
         image_height_ff <= imgrot_pkg::DIM_RESET;
      end else begin
         image_width_ff  <= image_width_in;
         image_height_ff <= image_height_in;
      end
   end

   always_comb begin
      unique case (csr_idx)
         imgrot_pkg::REG_IMAGE_WIDTH:  csr_prdata = imgrot_pkg::CSR_DATA_W'(image_width_ff);
         imgrot_pkg::REG_IMAGE_HEIGHT: csr_prdata = imgrot_pkg::CSR_DATA_W'(image_height_ff);
         default:                      csr_prdata = '0;
      endcase
   end

   // clamp dimensions into 1..MAX_DIM
   assign w_ext = CMP_W'(image_width_ff);
   assign h_ext = CMP_W'(image_height_ff);

   always_comb begin
      priority if (w_ext == '0) begin
         w_eff = CMP_W'(1);
      end else if (w_ext > CMP_W'(MAX_DIM)) begin
         w_eff = CMP_W'(MAX_DIM);
      end else begin
         w_eff = w_ext;
      end
      priority if (h_ext == '0) begin
         h_eff = CMP_W'(1);
      end else if (h_ext > CMP_W'(MAX_DIM)) begin
         h_eff = CMP_W'(MAX_DIM);
      end else begin
         h_eff = h_ext;
      end
   end

   assign w_dim = w_eff[DIM_W-1:0];
   assign h_dim = h_eff[DIM_W-1:0];

   imgrot_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_mode (req_data.mode),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .cmd      (cmd),
      .sts      (sts)
   );

   imgrot_dp #(
      .MAX_DIM(MAX_DIM)
   ) u_dp (
      .clock   (clock),
      .reset   (reset),
      .w_dim   (w_dim),
      .h_dim   (h_dim),
      .req_data(req_data),
      .cmd     (cmd),
      .sts     (sts),
      .rsp_data(rsp_data)
   );

   // input side only backs up behind a full, stalled output
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("req_stall without a stalled result");

   a_out_load: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid)
      else $error("output register loaded but no result shown");

   a_load_end: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_en && sts.load_wrap) |=> !cmd.load_en)
      else $error("pixel written after frame was complete");

   a_drain_end: assert property (@(posedge clock) disable iff (reset)
      (cmd.drain_en && sts.drain_wrap) |=> !cmd.drain_en)
      else $error("pixel read after last of frame");

endmodule

`default_nettype wire

[verif/image_rotate_90_ccw_core_tb.sv]
// Self-checking testbench for image_rotate_90_ccw_core: loads frames over the req channel,
// drains the rotated pixels and compares them with an in-bench rotation predictor.
// Depends on imgrot_pkg and the core RTL only.
module image_rotate_90_ccw_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DIM_LIMIT = imgrot_pkg::MAX_DIM_DEFAULT;
   localparam int LATENCY   = 4;

   logic                              clock       = 1'b0;
   logic                              reset       = 1'b1;
   logic                              req_valid   = 1'b0;
   logic                              req_stall;
   imgrot_pkg::req_type               req_data    = '0;
   logic                              rsp_valid;
   logic                              rsp_stall   = 1'b0;
   imgrot_pkg::rsp_type               rsp_data;
   logic                              csr_psel    = 1'b0;
   logic                              csr_penable = 1'b0;
   logic                              csr_pwrite  = 1'b0;
   logic [imgrot_pkg::CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [imgrot_pkg::CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [imgrot_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                              csr_pready;

   image_rotate_90_ccw_core #(.MAX_DIM(DIM_LIMIT)) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic [imgrot_pkg::PIXEL_W-1:0]   frame_mem [DIM_LIMIT*DIM_LIMIT];
   imgrot_pkg::state_type            rot_phase  = imgrot_pkg::ST_LOAD;
   int unsigned                      load_row   = 0;
   int unsigned                      load_col   = 0;
   int unsigned                      drain_row  = 0;
   int unsigned                      drain_col  = 0;
   logic [imgrot_pkg::DIM_REG_W-1:0] width_reg  = imgrot_pkg::DIM_RESET;
   logic [imgrot_pkg::DIM_REG_W-1:0] height_reg = imgrot_pkg::DIM_RESET;
   imgrot_pkg::rsp_type              rotated_q[$];

   int errors       = 0;
   bit send_idle_on = 1'b1;
   bit recv_idle_on = 1'b1;
   bit hold_pending = 1'b0;

   task automatic flag(string what);
      errors++;
      $display("%0t ns: %s", $time, what);
   endtask

   task automatic check_field(string name, int got, int want);
      if (got != want)
         flag($sformatf("%s: got %0d, expected %0d", name, got, want));
   endtask

   function automatic int unsigned eff_dim(logic [imgrot_pkg::DIM_REG_W-1:0] v);
      if (v == 0)
         return 1;
      if (v > DIM_LIMIT)
         return DIM_LIMIT;
      return 32'(v);
   endfunction

   function automatic int unsigned mem_index(int unsigned row, int unsigned col);
      return (row % DIM_LIMIT) * DIM_LIMIT + (col % DIM_LIMIT);
   endfunction

   // advance the predictor by one accepted beat; drains in drain phase queue a pixel
   function automatic void rotate_step(imgrot_pkg::req_type it);
      int unsigned                    w;
      int unsigned                    h;
      int unsigned                    src_col;
      logic [imgrot_pkg::PIXEL_W-1:0] px;
      imgrot_pkg::rsp_type            pix;
      w = eff_dim(width_reg);
      h = eff_dim(height_reg);
      if (it.mode == imgrot_pkg::MODE_LOAD) begin
         if (rot_phase == imgrot_pkg::ST_DRAIN)
            return;
         frame_mem[mem_index(load_row, load_col)] = {it.in_red, it.in_green, it.in_blue};
         load_col++;
         if (load_col >= w) begin
            load_col = 0;
            load_row++;
            if (load_row >= h) begin
               load_row  = 0;
               rot_phase = imgrot_pkg::ST_DRAIN;
            end
         end
      end else begin
         if (rot_phase == imgrot_pkg::ST_LOAD)
            return;
         // rows past a shrunken width fall back to source column 0
         src_col = (drain_row < w) ? w - 1 - drain_row : 0;
         px = frame_mem[mem_index(drain_col, src_col)];
         pix.out_blue  = px[imgrot_pkg::CHAN_W-1:0];
         pix.out_green = px[2*imgrot_pkg::CHAN_W-1:imgrot_pkg::CHAN_W];
         pix.out_red   = px[3*imgrot_pkg::CHAN_W-1:2*imgrot_pkg::CHAN_W];
         pix.out_row   = drain_row[imgrot_pkg::COORD_W-1:0];
         pix.out_col   = drain_col[imgrot_pkg::COORD_W-1:0];
         pix.last      = 1'b0;
         drain_col++;
         if (drain_col >= h) begin
            drain_col = 0;
            drain_row++;
            if (drain_row >= w) begin
               drain_row = 0;
               rot_phase = imgrot_pkg::ST_LOAD;
               pix.last  = 1'b1;
            end
         end
         rotated_q.push_back(pix);
      end
   endfunction

   always @(posedge clock) begin : rsp_check
      imgrot_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rotated_q.size() == 0) begin
            flag("result beat with nothing expected");
         end else begin
            want = rotated_q.pop_front();
            check_field("out_blue", int'(rsp_data.out_blue), int'(want.out_blue));
            check_field("out_green", int'(rsp_data.out_green), int'(want.out_green));
            check_field("out_red", int'(rsp_data.out_red), int'(want.out_red));
            check_field("out_row", int'(rsp_data.out_row), int'(want.out_row));
            check_field("out_col", int'(rsp_data.out_col), int'(want.out_col));
            check_field("last", int'(rsp_data.last), int'(want.last));
         end
      end
   end

   // receiver: random stall runs, plus a long hold-off on request
   initial begin : rsp_backpressure
      int unsigned hold_left;
      int unsigned run_left;
      int unsigned n;
      bit          stall_now;
      hold_left = 0;
      run_left  = 0;
      stall_now = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            hold_left    = 120;
         end
         if (hold_left > 0) begin
            hold_left--;
            stall_now = 1'b1;
         end else if (!recv_idle_on) begin
            stall_now = 1'b0;
         end else if (run_left > 0) begin
            run_left--;
         end else begin
            n = $urandom_range(0, 99);
            if (n < 60) begin
               stall_now = 1'b0;
               run_left  = $urandom_range(0, 6);
            end else if (n < 95) begin
               stall_now = 1'b1;
               run_left  = $urandom_range(0, 2);
            end else begin
               stall_now = 1'b1;
               run_left  = $urandom_range(10, 40);
            end
         end
         rsp_stall <= stall_now;
      end
   end

   function automatic int unsigned pick_gap();
      int unsigned n;
      if (!send_idle_on)
         return 0;
      n = $urandom_range(0, 99);
      if (n < 65)
         return 0;
      if (n < 95)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic imgrot_pkg::req_type make_item(logic m);
      imgrot_pkg::req_type it;
      it.mode     = m;
      it.in_blue  = 8'($urandom_range(0, 255));
      it.in_green = 8'($urandom_range(0, 255));
      it.in_red   = 8'($urandom_range(0, 255));
      return it;
   endfunction

   // valid stays high between back-to-back beats; it only drops for a gap
   task automatic send_item(imgrot_pkg::req_type it);
      int unsigned gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (req_stall);
      rotate_step(it);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (rotated_q.size() != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   task automatic csr_access(logic wr, logic reg_code,
                             logic [imgrot_pkg::CSR_DATA_W-1:0] wdata,
                             output logic [imgrot_pkg::CSR_DATA_W-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= imgrot_pkg::CSR_ADDR_W'(reg_code) << imgrot_pkg::CSR_IDX_BIT;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_dim(logic reg_code, logic [imgrot_pkg::DIM_REG_W-1:0] v);
      logic [imgrot_pkg::CSR_DATA_W-1:0] wdata;
      logic [imgrot_pkg::CSR_DATA_W-1:0] rdata;
      wdata = $urandom;
      wdata[imgrot_pkg::DIM_REG_W-1:0] = v;
      csr_access(1'b1, reg_code, wdata, rdata);
      if (reg_code == imgrot_pkg::REG_IMAGE_WIDTH)
         width_reg = v;
      else
         height_reg = v;
      csr_access(1'b0, reg_code, '0, rdata);
      if (rdata != imgrot_pkg::CSR_DATA_W'(v))
         flag($sformatf("register %0d reads %0h, expected %0h", reg_code, rdata, v));
   endtask

   task automatic set_dims(logic [imgrot_pkg::DIM_REG_W-1:0] w,
                           logic [imgrot_pkg::DIM_REG_W-1:0] h);
      write_dim(imgrot_pkg::REG_IMAGE_WIDTH, w);
      write_dim(imgrot_pkg::REG_IMAGE_HEIGHT, h);
   endtask

   // noise beats are of the wrong phase and must be dropped
   task automatic load_frame(int unsigned noise_pct);
      while (rot_phase == imgrot_pkg::ST_LOAD) begin
         if ($urandom_range(0, 99) < noise_pct)
            send_item(make_item(imgrot_pkg::MODE_DRAIN));
         else
            send_item(make_item(imgrot_pkg::MODE_LOAD));
      end
   endtask

   task automatic drain_frame(int unsigned noise_pct);
      while (rot_phase == imgrot_pkg::ST_DRAIN) begin
         if ($urandom_range(0, 99) < noise_pct)
            send_item(make_item(imgrot_pkg::MODE_LOAD));
         else
            send_item(make_item(imgrot_pkg::MODE_DRAIN));
      end
   endtask

   task automatic test_reset_values();
      logic [imgrot_pkg::CSR_DATA_W-1:0] rdata;
      csr_access(1'b0, imgrot_pkg::REG_IMAGE_WIDTH, '0, rdata);
      if (rdata != imgrot_pkg::CSR_DATA_W'(imgrot_pkg::DIM_RESET))
         flag($sformatf("image_width after reset reads %0d", rdata));
      csr_access(1'b0, imgrot_pkg::REG_IMAGE_HEIGHT, '0, rdata);
      if (rdata != imgrot_pkg::CSR_DATA_W'(imgrot_pkg::DIM_RESET))
         flag($sformatf("image_height after reset reads %0d", rdata));
      // drains while loading give nothing
      repeat (3) send_item(make_item(imgrot_pkg::MODE_DRAIN));
      settle();
   endtask

   task automatic test_tiny_frames();
      set_dims(8'd1, 8'd1);
      send_item(imgrot_pkg::req_type'{imgrot_pkg::MODE_LOAD, 8'h00, 8'h00, 8'h00});
      send_item(make_item(imgrot_pkg::MODE_LOAD));
      send_item(make_item(imgrot_pkg::MODE_DRAIN));
      settle();
      // zero acts as one
      set_dims(8'd0, 8'd0);
      send_item(imgrot_pkg::req_type'{imgrot_pkg::MODE_LOAD, 8'hFF, 8'hFF, 8'hFF});
      send_item(make_item(imgrot_pkg::MODE_DRAIN));
      send_item(make_item(imgrot_pkg::MODE_DRAIN));
      settle();
   endtask

   // full-range coordinates on thin strips; oversize values clamp to MAX_DIM
   task automatic test_dimension_extremes();
      set_dims(8'd255, 8'd1);
      load_frame(0);
      drain_frame(0);
      settle();
      set_dims(8'd1, 8'd200);
      load_frame(0);
      drain_frame(0);
      settle();
   endtask

   task automatic test_resize_mid_frame();
      // seed an 8x8 region so every read below hits loaded pixels
      set_dims(8'd8, 8'd8);
      load_frame(0);
      drain_frame(0);
      settle();
      set_dims(8'd6, 8'd5);
      repeat (10) send_item(make_item(imgrot_pkg::MODE_LOAD));
      settle();
      // load_col is now past the new width and wraps on the next load
      set_dims(8'd3, 8'd5);
      load_frame(0);
      repeat (11) send_item(make_item(imgrot_pkg::MODE_DRAIN));
      settle();
      // drain_row beyond width, drain_col beyond height
      set_dims(8'd2, 8'd1);
      drain_frame(0);
      settle();
   endtask

   task automatic test_backpressure();
      set_dims(8'd4, 8'd4);
      load_frame(0);
      send_idle_on = 1'b0;
      hold_pending = 1'b1;
      drain_frame(0);
      send_idle_on = 1'b1;
      settle();
   endtask

   function automatic logic [imgrot_pkg::DIM_REG_W-1:0] pick_dim();
      int unsigned n;
      n = $urandom_range(0, 99);
      if (n < 8)
         return '0;
      if (n < 85)
         return 8'($urandom_range(1, 6));
      return 8'($urandom_range(7, 20));
   endfunction

   task automatic test_random_frames();
      int unsigned beats;
      beats = 0;
      while (beats < 500) begin
         send_idle_on = ($urandom_range(0, 4) != 0);
         recv_idle_on = ($urandom_range(0, 4) != 0);
         set_dims(pick_dim(), pick_dim());
         beats += 2 * eff_dim(width_reg) * eff_dim(height_reg);
         load_frame(8);
         drain_frame(8);
         settle();
      end
      send_idle_on = 1'b1;
      recv_idle_on = 1'b1;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_reset_values();
      test_tiny_frames();
      test_dimension_extremes();
      test_resize_mid_frame();
      test_backpressure();
      test_random_frames();
      settle();
      if (errors == 0)
         $display("image_rotate_90_ccw_core: match");
      else
         $display("image_rotate_90_ccw_core: mismatch");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("image_rotate_90_ccw_core: mismatch");
      $finish;
   end

endmodule

[files.f]
hw/rtl/imgrot_pkg.sv
hw/rtl/imgrot_ram.sv
hw/rtl/imgrot_ctrl.sv
hw/rtl/imgrot_dp.sv
hw/rtl/image_rotate_90_ccw_core.sv
verif/image_rotate_90_ccw_core_tb.sv
